// ----- rtl/core/bezier_pkg.sv -----
package bezier_pkg;

   // coordinate and curve parameter formats
   localparam int COORD_WIDTH = 16;
   localparam int T_FRAC_BITS = 16;

   localparam int NUM_COORDS = 3;
   localparam int NUM_POINTS = 4;
   localparam int POINT_W    = NUM_COORDS * COORD_WIDTH;

   // t and 1-t hold 0..ONE
   localparam int T_W  = T_FRAC_BITS + 1;
   // weights carry headroom for the 3x terms
   localparam int W_W  = T_FRAC_BITS + 2;
   // raw weight products before rounding
   localparam int PR_W = 2 * T_W + 2;
   // weight times coordinate, weight zero-extended to signed
   localparam int P_W  = W_W + 1 + COORD_WIDTH;
   // sum of four products
   localparam int A_W  = P_W + 2;

   localparam int NUM_STAGES = 6;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = POINT_W;

   typedef logic [T_W-1:0]                tval_type;
   typedef logic [W_W-1:0]                weight_type;
   typedef logic [PR_W-1:0]               wprod_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [P_W-1:0]         prod_type;
   typedef logic signed [A_W-1:0]         acc_type;
   typedef logic [POINT_W-1:0]            point_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURVE_MODE  = 3'd0,
      CSR_START_POINT = 3'd1,
      CSR_CONTROL_ONE = 3'd2,
      CSR_CONTROL_TWO = 3'd3,
      CSR_END_POINT   = 3'd4
   } csr_index_type;

   localparam tval_type  T_ONE    = {1'b1, {T_FRAC_BITS{1'b0}}};
   localparam wprod_type PR_HALF  = wprod_type'(1) << (T_FRAC_BITS - 1);
   localparam acc_type   ACC_HALF = acc_type'(1) << (T_FRAC_BITS - 1);
   localparam acc_type   ACC_MAX  = (acc_type'(1) << (COORD_WIDTH - 1)) - acc_type'(1);
   localparam acc_type   ACC_MIN  = -ACC_MAX - acc_type'(1);

   // round a Q(2*frac) product to Q(frac), half up
   function automatic weight_type rnd_w(input wprod_type v);
      wprod_type s;
      s = v + PR_HALF;
      return weight_type'(s >> T_FRAC_BITS);
   endfunction

endpackage

// ----- rtl/core/bezier_curve_point_evaluator.sv -----
// latency: six register stages; rsp_valid is the valid bit of the last stage
// throughput: one request per cycle unless rsp_ready stalls a full pipeline; stages 2, 3 and 4
//    each own their multipliers, so nothing is shared between items
// each stage advances when its successor is empty or moving, so bubbles collapse
// reset (synchronous, active high) clears the valid bits and the configuration registers;
//    datapath registers are not reset
module bezier_curve_point_evaluator (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [bezier_pkg::T_W-1:0]                req_t_value,
   // result channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [bezier_pkg::COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [bezier_pkg::COORD_WIDTH-1:0] rsp_point_y,
   output logic signed [bezier_pkg::COORD_WIDTH-1:0] rsp_point_z,
   // configuration write port
   input  logic                                      csr_we,
   input  logic [bezier_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [bezier_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic                  mode_ff, mode_in;
   bezier_pkg::point_type pts_ff [bezier_pkg::NUM_POINTS];
   bezier_pkg::point_type pts_in [bezier_pkg::NUM_POINTS];

   always_comb begin
      mode_in = mode_ff;
      for (int p = 0; p < bezier_pkg::NUM_POINTS; p++) begin
         pts_in[p] = pts_ff[p];
      end
      if (csr_we) begin
         unique case (csr_index)
            bezier_pkg::CSR_CURVE_MODE:  mode_in   = csr_wdata[0];
            bezier_pkg::CSR_START_POINT: pts_in[0] = csr_wdata[bezier_pkg::POINT_W-1:0];
            bezier_pkg::CSR_CONTROL_ONE: pts_in[1] = csr_wdata[bezier_pkg::POINT_W-1:0];
            bezier_pkg::CSR_CONTROL_TWO: pts_in[2] = csr_wdata[bezier_pkg::POINT_W-1:0];
            bezier_pkg::CSR_END_POINT:   pts_in[3] = csr_wdata[bezier_pkg::POINT_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         for (int p = 0; p < bezier_pkg::NUM_POINTS; p++) begin
            pts_ff[p] <= '0;
         end
      end else begin
         mode_ff <= mode_in;
         for (int p = 0; p < bezier_pkg::NUM_POINTS; p++) begin
            pts_ff[p] <= pts_in[p];
         end
      end
   end

   // ------------------------------------------------------------------
   // pipeline flow control
   // stage k may load when it is empty or its own content moves on
   // ------------------------------------------------------------------
   logic [bezier_pkg::NUM_STAGES-1:0] valid_ff, valid_in;
   logic [bezier_pkg::NUM_STAGES:0]   adv;

   always_comb begin
      adv[bezier_pkg::NUM_STAGES] = rsp_ready;
      for (int k = bezier_pkg::NUM_STAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < bezier_pkg::NUM_STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[bezier_pkg::NUM_STAGES-1];

   // ------------------------------------------------------------------
   // stage 1: clamp t to one, form u = 1 - t
   // ------------------------------------------------------------------
   bezier_pkg::tval_type s1_t_ff, s1_t_in, s1_u_ff, s1_u_in;

   always_comb begin
      s1_t_in = (req_t_value > bezier_pkg::T_ONE) ? bezier_pkg::T_ONE : req_t_value;
      s1_u_in = bezier_pkg::T_ONE - s1_t_in;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_t_ff <= s1_t_in;
         s1_u_ff <= s1_u_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: squares and the quadratic cross term
   // ------------------------------------------------------------------
   bezier_pkg::tval_type   s2_t_ff, s2_u_ff, s2_uu_ff, s2_tt_ff;
   bezier_pkg::tval_type   s2_uu_in, s2_tt_in;
   bezier_pkg::weight_type s2_tu2_ff, s2_tu2_in;

   always_comb begin
      s2_uu_in  = bezier_pkg::tval_type'(bezier_pkg::rnd_w(
                     bezier_pkg::wprod_type'(s1_u_ff) * bezier_pkg::wprod_type'(s1_u_ff)));
      s2_tt_in  = bezier_pkg::tval_type'(bezier_pkg::rnd_w(
                     bezier_pkg::wprod_type'(s1_t_ff) * bezier_pkg::wprod_type'(s1_t_ff)));
      // 2*t*u as a shift of the product
      s2_tu2_in = bezier_pkg::rnd_w(
                     (bezier_pkg::wprod_type'(s1_t_ff) * bezier_pkg::wprod_type'(s1_u_ff)) << 1);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_t_ff   <= s1_t_ff;
         s2_u_ff   <= s1_u_ff;
         s2_uu_ff  <= s2_uu_in;
         s2_tt_ff  <= s2_tt_in;
         s2_tu2_ff <= s2_tu2_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: bernstein weights for the selected curve order
   // ------------------------------------------------------------------
   bezier_pkg::weight_type s3_w_ff [bezier_pkg::NUM_POINTS];
   bezier_pkg::weight_type s3_w_in [bezier_pkg::NUM_POINTS];
   bezier_pkg::wprod_type  uuu_p, uut_p, utt_p, ttt_p;

   always_comb begin
      uuu_p = bezier_pkg::wprod_type'(s2_uu_ff) * bezier_pkg::wprod_type'(s2_u_ff);
      uut_p = bezier_pkg::wprod_type'(s2_uu_ff) * bezier_pkg::wprod_type'(s2_t_ff);
      utt_p = bezier_pkg::wprod_type'(s2_u_ff) * bezier_pkg::wprod_type'(s2_tt_ff);
      ttt_p = bezier_pkg::wprod_type'(s2_tt_ff) * bezier_pkg::wprod_type'(s2_t_ff);
      if (mode_ff) begin
         s3_w_in[0] = bezier_pkg::rnd_w(uuu_p);
         s3_w_in[1] = bezier_pkg::rnd_w(uut_p + (uut_p << 1));
         s3_w_in[2] = bezier_pkg::rnd_w(utt_p + (utt_p << 1));
         s3_w_in[3] = bezier_pkg::rnd_w(ttt_p);
      end else begin
         // quadratic: second control point carries no weight
         s3_w_in[0] = bezier_pkg::weight_type'(s2_uu_ff);
         s3_w_in[1] = s2_tu2_ff;
         s3_w_in[2] = '0;
         s3_w_in[3] = bezier_pkg::weight_type'(s2_tt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int p = 0; p < bezier_pkg::NUM_POINTS; p++) begin
            s3_w_ff[p] <= s3_w_in[p];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 4: weight times coordinate, twelve multipliers
   // ------------------------------------------------------------------
   bezier_pkg::prod_type s4_prod_ff [bezier_pkg::NUM_COORDS][bezier_pkg::NUM_POINTS];
   bezier_pkg::prod_type s4_prod_in [bezier_pkg::NUM_COORDS][bezier_pkg::NUM_POINTS];
   logic signed [bezier_pkg::W_W:0] w_s [bezier_pkg::NUM_POINTS];
   bezier_pkg::coord_type           crd [bezier_pkg::NUM_COORDS][bezier_pkg::NUM_POINTS];

   always_comb begin
      for (int p = 0; p < bezier_pkg::NUM_POINTS; p++) begin
         w_s[p] = $signed({1'b0, s3_w_ff[p]});
      end
      for (int c = 0; c < bezier_pkg::NUM_COORDS; c++) begin
         for (int p = 0; p < bezier_pkg::NUM_POINTS; p++) begin
            crd[c][p] = $signed(pts_ff[p][c*bezier_pkg::COORD_WIDTH +: bezier_pkg::COORD_WIDTH]);
            s4_prod_in[c][p] = bezier_pkg::prod_type'(w_s[p])
                             * bezier_pkg::prod_type'(crd[c][p]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int c = 0; c < bezier_pkg::NUM_COORDS; c++) begin
            for (int p = 0; p < bezier_pkg::NUM_POINTS; p++) begin
               s4_prod_ff[c][p] <= s4_prod_in[c][p];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 5: exact weighted sum per coordinate
   // ------------------------------------------------------------------
   bezier_pkg::acc_type s5_acc_ff [bezier_pkg::NUM_COORDS];
   bezier_pkg::acc_type s5_acc_in [bezier_pkg::NUM_COORDS];

   always_comb begin
      for (int c = 0; c < bezier_pkg::NUM_COORDS; c++) begin
         s5_acc_in[c] = bezier_pkg::acc_type'(s4_prod_ff[c][0])
                      + bezier_pkg::acc_type'(s4_prod_ff[c][1])
                      + bezier_pkg::acc_type'(s4_prod_ff[c][2])
                      + bezier_pkg::acc_type'(s4_prod_ff[c][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int c = 0; c < bezier_pkg::NUM_COORDS; c++) begin
            s5_acc_ff[c] <= s5_acc_in[c];
         end
      end
   end

   // ------------------------------------------------------------------
   // stage 6: round half up (floor after adding half), saturate; output register
   // ------------------------------------------------------------------
   bezier_pkg::coord_type s6_pt_ff [bezier_pkg::NUM_COORDS];
   bezier_pkg::coord_type s6_pt_in [bezier_pkg::NUM_COORDS];
   bezier_pkg::acc_type   rq [bezier_pkg::NUM_COORDS];

   always_comb begin
      for (int c = 0; c < bezier_pkg::NUM_COORDS; c++) begin
         rq[c] = (s5_acc_ff[c] + bezier_pkg::ACC_HALF) >>> bezier_pkg::T_FRAC_BITS;
         priority if (rq[c] > bezier_pkg::ACC_MAX) begin
            s6_pt_in[c] = bezier_pkg::coord_type'(bezier_pkg::ACC_MAX);
         end else if (rq[c] < bezier_pkg::ACC_MIN) begin
            s6_pt_in[c] = bezier_pkg::coord_type'(bezier_pkg::ACC_MIN);
         end else begin
            s6_pt_in[c] = rq[c][bezier_pkg::COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int c = 0; c < bezier_pkg::NUM_COORDS; c++) begin
            s6_pt_ff[c] <= s6_pt_in[c];
         end
      end
   end

   assign rsp_point_x = s6_pt_ff[0];
   assign rsp_point_y = s6_pt_ff[1];
   assign rsp_point_z = s6_pt_ff[2];

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   logic [bezier_pkg::T_W:0] s1_sum;
   assign s1_sum = {1'b0, s1_t_ff} + {1'b0, s1_u_ff};

   // clamped t and u always partition one
   a_t_u_sum: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (s1_sum == {1'b0, bezier_pkg::T_ONE}))
      else $error("t and u do not sum to one");

   // squared terms never exceed one
   a_sq_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (s2_uu_ff <= bezier_pkg::T_ONE && s2_tt_ff <= bezier_pkg::T_ONE))
      else $error("squared weight above one");

   // quadratic mode leaves the second control point unweighted
   a_quad_w2: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !mode_ff |-> (s3_w_ff[2] == '0))
      else $error("second control weight nonzero in quadratic mode");

   // a full, stalled pipeline must refuse new requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_ready |-> !req_ready)
      else $error("request accepted into a full stalled pipeline");

   // a stalled stage keeps its item
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !adv[4] |=> valid_ff[3])
      else $error("stalled item lost in product stage");

endmodule
